>>> design/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define NT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define NT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ntab_pkg.sv
// Types and constants of the neighbor table.
// No dependencies; used by all modules.
package ntab_pkg;

    localparam int ENTRIES_DEF     = 16;
    localparam int MAX_REPORT      = 16;
    localparam int CNT_W           = $clog2(MAX_REPORT + 1);
    localparam int SLOT_W          = 4;
    localparam logic [15:0] DEAD_LIMIT_RST = 16'd40;

    typedef enum logic [2:0] {
        OP_HELLO  = 3'd0,
        OP_BIDIR  = 3'd1,
        OP_STUB   = 3'd2,
        OP_REMOVE = 3'd3,
        OP_TICK   = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        ST_INSERTED  = 4'd0,
        ST_REFRESHED = 4'd1,
        ST_CHANGED   = 4'd2,
        ST_UNCHANGED = 4'd3,
        ST_NOT_FOUND = 4'd4,
        ST_FULL      = 4'd5,
        ST_REMOVED   = 4'd6,
        ST_EXPIRED   = 4'd7,
        ST_TICK_DONE = 4'd8
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [31:0] neighbor;
        logic [31:0] loc_addr;
        logic [7:0]  port;
        logic        stub;
        logic        bidir;
        logic [15:0] age;
    } t_rec;

    // Controller to datapath; the 6-bit index field covers tables of up to 64 slots.
    typedef struct packed {
        logic       start;
        logic       rd_en;
        logic [5:0] rd_idx;
        logic       finish;
    } t_dp_cmd;

endpackage

>>> design/neighbor_table_with_aging.sv
// Top level of the neighbor table with aging.
// Depends on ntab_pkg, ntab_ctrl and ntab_dp.
//
// Command channel: an op is taken at a rising edge with start high and
// busy low; i_opcode selects hello, mark bidirectional, mark stub,
// remove or tick, the other fields key and describe the neighbor.
// Result channel: each result sits on the o_ ports for one cycle with
// o_strobe high; o_last marks the final result of an op. A tick reports
// each expired entry, at most MAX_REPORT per tick, in slot order, then one
// closing result. Timing: every known op reads the slot memory once per
// slot over its single read port, and a new op is taken only after the
// last one has closed. An unknown opcode skips the slot walk.
// Configuration: i_cfg_we writes i_cfg_wdata into the dead limit; write it
// only between ops.
// Reset (synchronous, active low) clears all valid bits at once and sets
// the dead limit to 40; the first op may follow directly.
// The receiver cannot stall: results are not held.
module neighbor_table_with_aging #(
    parameter int ENTRIES = ntab_pkg::ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_neighbor_addr,
    input  logic [31:0] i_local_addr,
    input  logic [7:0]  i_port_id,
    output logic        o_strobe,
    output logic [3:0]  o_status,
    output logic [3:0]  o_slot,
    output logic [31:0] o_out_neighbor_addr,
    output logic [31:0] o_out_local_addr,
    output logic [7:0]  o_out_port_id,
    output logic        o_last
);

    ntab_pkg::t_dp_cmd cmd;

    ntab_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    ntab_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_opcode            (i_opcode),
        .i_neighbor_addr     (i_neighbor_addr),
        .i_local_addr        (i_local_addr),
        .i_port_id           (i_port_id),
        .o_strobe            (o_strobe),
        .o_status            (o_status),
        .o_slot              (o_slot),
        .o_out_neighbor_addr (o_out_neighbor_addr),
        .o_out_local_addr    (o_out_local_addr),
        .o_out_port_id       (o_out_port_id),
        .o_last              (o_last)
    );

endmodule

>>> design/ntab_ctrl.sv
// Sequencer of the neighbor table: walks the slots and closes each op.
// Depends on ntab_pkg.
module ntab_ctrl #(
    parameter int ENTRIES = ntab_pkg::ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [2:0]        i_opcode,
    output logic              o_busy,
    output ntab_pkg::t_dp_cmd o_cmd
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    ntab_pkg::t_state r_state, n_state;
    logic [IW-1:0]    r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ntab_pkg::S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        o_busy       = (r_state != ntab_pkg::S_IDLE);
        o_cmd        = '0;
        o_cmd.rd_idx = 6'(r_idx);
        case (r_state)
            ntab_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.start = 1'b1;
                    n_idx       = '0;
                    // unknown opcodes need no scan
                    if (i_opcode > 3'(ntab_pkg::OP_TICK)) n_state = ntab_pkg::S_DONE;
                    else                                   n_state = ntab_pkg::S_SCAN;
                end
            end
            ntab_pkg::S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (r_idx == IW'(ENTRIES - 1)) n_state = ntab_pkg::S_DRAIN;
                else                           n_idx   = r_idx + 1'b1;
            end
            ntab_pkg::S_DRAIN: begin
                // last slot read is processed here
                n_state = ntab_pkg::S_DONE;
            end
            ntab_pkg::S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = ntab_pkg::S_IDLE;
            end
            default: n_state = ntab_pkg::S_IDLE;
        endcase
    end

endmodule

>>> design/ntab_dp.sv
// Datapath of the neighbor table: slot memory, valid bits, lookup and aging.
// Depends on ntab_pkg; driven by ntab_ctrl commands.
module ntab_dp #(
    parameter int ENTRIES = ntab_pkg::ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ntab_pkg::t_dp_cmd i_cmd,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    input  logic [2:0]        i_opcode,
    input  logic [31:0]       i_neighbor_addr,
    input  logic [31:0]       i_local_addr,
    input  logic [7:0]        i_port_id,
    output logic              o_strobe,
    output logic [3:0]        o_status,
    output logic [3:0]        o_slot,
    output logic [31:0]       o_out_neighbor_addr,
    output logic [31:0]       o_out_local_addr,
    output logic [7:0]        o_out_port_id,
    output logic              o_last
);

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int EXTW = (IW > ntab_pkg::SLOT_W) ? IW : ntab_pkg::SLOT_W;
    localparam int CW   = ntab_pkg::CNT_W;

    ntab_pkg::t_rec r_mem [ENTRIES];
    ntab_pkg::t_rec r_rd_data;

    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [15:0]        r_dead_limit;

    logic [2:0]     r_op;
    logic [31:0]    r_key, r_laddr;
    logic [7:0]     r_port;

    logic           r_proc_en;
    logic [IW-1:0]  r_proc_idx;

    logic           r_hit, n_hit, r_free, n_free;
    logic [IW-1:0]  r_hit_idx, n_hit_idx, r_free_idx, n_free_idx;
    ntab_pkg::t_rec r_hit_rec, n_hit_rec;
    logic [CW-1:0]  r_cnt, n_cnt;

    logic           mem_we;
    logic [IW-1:0]  mem_wa;
    ntab_pkg::t_rec mem_wd;

    logic                r_o_strobe, n_o_strobe;
    ntab_pkg::t_status   r_o_status, n_o_status;
    logic [IW-1:0]       r_o_idx, n_o_idx;
    logic [31:0]         r_o_naddr, n_o_naddr, r_o_laddr, n_o_laddr;
    logic [7:0]          r_o_port, n_o_port;
    logic                r_o_last, n_o_last;
    logic [EXTW-1:0]     slot_ext;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) r_rd_data <= r_mem[i_cmd.rd_idx[IW-1:0]];
        if (mem_we)      r_mem[mem_wa] <= mem_wd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_dead_limit <= ntab_pkg::DEAD_LIMIT_RST;
            r_proc_en    <= 1'b0;
            r_hit        <= 1'b0;
            r_free       <= 1'b0;
            r_cnt        <= '0;
            r_o_strobe   <= 1'b0;
        end else begin
            r_valid    <= n_valid;
            r_proc_en  <= i_cmd.rd_en;
            r_hit      <= n_hit;
            r_free     <= n_free;
            r_cnt      <= n_cnt;
            r_o_strobe <= n_o_strobe;
            if (i_cfg_we) r_dead_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op    <= i_opcode;
            r_key   <= i_neighbor_addr;
            r_laddr <= i_local_addr;
            r_port  <= i_port_id;
        end
        r_proc_idx <= i_cmd.rd_idx[IW-1:0];
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_hit_rec  <= n_hit_rec;
        r_o_status <= n_o_status;
        r_o_idx    <= n_o_idx;
        r_o_naddr  <= n_o_naddr;
        r_o_laddr  <= n_o_laddr;
        r_o_port   <= n_o_port;
        r_o_last   <= n_o_last;
    end

    always_comb begin
        ntab_pkg::t_rec rec;
        ntab_pkg::t_rec w_rec;
        logic           v;
        logic [15:0]    age_inc;

        rec        = r_rd_data;
        w_rec      = r_hit_rec;
        v          = r_valid[r_proc_idx];
        age_inc    = (rec.age == 16'hFFFF) ? rec.age : rec.age + 16'd1;

        n_valid    = r_valid;
        n_hit      = r_hit;
        n_free     = r_free;
        n_hit_idx  = r_hit_idx;
        n_free_idx = r_free_idx;
        n_hit_rec  = r_hit_rec;
        n_cnt      = r_cnt;
        mem_we     = 1'b0;
        mem_wa     = r_proc_idx;
        mem_wd     = rec;
        n_o_strobe = 1'b0;
        n_o_status = ntab_pkg::ST_UNCHANGED;
        n_o_idx    = '0;
        n_o_naddr  = r_key;
        n_o_laddr  = '0;
        n_o_port   = '0;
        n_o_last   = 1'b0;

        if (i_cmd.start) begin
            n_hit  = 1'b0;
            n_free = 1'b0;
            n_cnt  = '0;
        end

        if (r_proc_en) begin
            if (r_op == 3'(ntab_pkg::OP_TICK)) begin
                if (v) begin
                    if (!rec.stub && age_inc > r_dead_limit &&
                        r_cnt < CW'(ntab_pkg::MAX_REPORT)) begin
                        // drop the entry and report it
                        n_valid[r_proc_idx] = 1'b0;
                        n_cnt      = r_cnt + 1'b1;
                        n_o_strobe = 1'b1;
                        n_o_status = ntab_pkg::ST_EXPIRED;
                        n_o_idx    = r_proc_idx;
                        n_o_naddr  = rec.neighbor;
                        n_o_laddr  = rec.loc_addr;
                        n_o_port   = rec.port;
                    end else begin
                        mem_we     = 1'b1;
                        mem_wd     = rec;
                        mem_wd.age = age_inc;
                    end
                end
            end else begin
                if (v && rec.neighbor == r_key && !r_hit) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_proc_idx;
                    n_hit_rec = rec;
                end
                if (!v && !r_free) begin
                    n_free     = 1'b1;
                    n_free_idx = r_proc_idx;
                end
            end
        end

        if (i_cmd.finish) begin
            n_o_strobe = 1'b1;
            n_o_last   = 1'b1;
            if (r_hit) begin
                n_o_idx   = r_hit_idx;
                n_o_naddr = r_hit_rec.neighbor;
                n_o_laddr = r_hit_rec.loc_addr;
                n_o_port  = r_hit_rec.port;
            end
            mem_wa = r_hit_idx;
            case (r_op)
                ntab_pkg::OP_TICK: begin
                    n_o_status = ntab_pkg::ST_TICK_DONE;
                    n_o_naddr  = '0;
                end
                ntab_pkg::OP_HELLO: begin
                    if (r_hit) begin
                        n_o_status = ntab_pkg::ST_REFRESHED;
                        w_rec.age  = '0;
                        mem_we     = 1'b1;
                        mem_wd     = w_rec;
                    end else if (r_free) begin
                        n_o_status          = ntab_pkg::ST_INSERTED;
                        n_o_idx             = r_free_idx;
                        n_o_laddr           = r_laddr;
                        n_o_port            = r_port;
                        n_valid[r_free_idx] = 1'b1;
                        mem_we              = 1'b1;
                        mem_wa              = r_free_idx;
                        mem_wd.neighbor     = r_key;
                        mem_wd.loc_addr     = r_laddr;
                        mem_wd.port         = r_port;
                        mem_wd.stub         = 1'b0;
                        mem_wd.bidir        = 1'b0;
                        mem_wd.age          = '0;
                    end else begin
                        n_o_status = ntab_pkg::ST_FULL;
                    end
                end
                ntab_pkg::OP_BIDIR: begin
                    if (!r_hit)                 n_o_status = ntab_pkg::ST_NOT_FOUND;
                    else if (r_hit_rec.bidir)   n_o_status = ntab_pkg::ST_UNCHANGED;
                    else begin
                        n_o_status  = ntab_pkg::ST_CHANGED;
                        w_rec.bidir = 1'b1;
                        mem_we      = 1'b1;
                        mem_wd      = w_rec;
                    end
                end
                ntab_pkg::OP_STUB: begin
                    if (!r_hit)                 n_o_status = ntab_pkg::ST_NOT_FOUND;
                    else if (r_hit_rec.stub)    n_o_status = ntab_pkg::ST_UNCHANGED;
                    else begin
                        n_o_status = ntab_pkg::ST_CHANGED;
                        w_rec.stub = 1'b1;
                        mem_we     = 1'b1;
                        mem_wd     = w_rec;
                    end
                end
                ntab_pkg::OP_REMOVE: begin
                    if (!r_hit) n_o_status = ntab_pkg::ST_NOT_FOUND;
                    else begin
                        n_o_status         = ntab_pkg::ST_REMOVED;
                        n_valid[r_hit_idx] = 1'b0;
                    end
                end
                default: begin
                    // unknown opcode: no lookup was run
                    n_o_status = ntab_pkg::ST_UNCHANGED;
                    n_o_idx    = '0;
                    n_o_naddr  = r_key;
                    n_o_laddr  = '0;
                    n_o_port   = '0;
                end
            endcase
        end
    end

    assign slot_ext            = EXTW'(r_o_idx);
    assign o_strobe            = r_o_strobe;
    assign o_status            = r_o_status;
    assign o_slot              = slot_ext[ntab_pkg::SLOT_W-1:0];
    assign o_out_neighbor_addr = r_o_naddr;
    assign o_out_local_addr    = r_o_laddr;
    assign o_out_port_id       = r_o_port;
    assign o_last              = r_o_last;

endmodule

>>> design/ntab_checker.sv
// Port-level checks of the neighbor table, bound to the top level.
// Depends on assert_macros.svh and ntab_pkg.
`include "assert_macros.svh"

module ntab_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic [3:0]  o_status,
    input logic [3:0]  o_slot,
    input logic [31:0] o_out_neighbor_addr,
    input logic        o_last
);

    `NT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "op taken but not busy")
    `NT_ASSERT_NOW(a_mid_expired, i_clk, i_rst_n, o_strobe && !o_last, o_status == 4'(ntab_pkg::ST_EXPIRED), "non-final beat is not an expiry")
    `NT_ASSERT_NOW(a_mid_busy, i_clk, i_rst_n, o_strobe && !o_last, busy, "expiry beat after op closed")
    `NT_ASSERT_NEXT(a_last_gap, i_clk, i_rst_n, o_strobe && o_last, !o_strobe, "beat right after final beat")
    `NT_ASSERT_NOW(a_tick_done, i_clk, i_rst_n, o_strobe && o_status == 4'(ntab_pkg::ST_TICK_DONE), o_last && o_slot == 4'd0 && o_out_neighbor_addr == 32'd0, "malformed tick close")

endmodule

bind neighbor_table_with_aging ntab_checker u_ntab_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .start               (start),
    .busy                (busy),
    .o_strobe            (o_strobe),
    .o_status            (o_status),
    .o_slot              (o_slot),
    .o_out_neighbor_addr (o_out_neighbor_addr),
    .o_last              (o_last)
);
